>>> hdl/smootherstep_light_fade_unit_assert.svh
// Assertion macros for the smootherstep light fade unit
`ifndef SMOOTHERSTEP_LIGHT_FADE_UNIT_ASSERT_SVH
`define SMOOTHERSTEP_LIGHT_FADE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, ignored in reset
`define SLF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slf assertion failed");

// next-cycle implication
`define SLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slf assertion failed");

`endif

>>> hdl/slf_pkg.sv
// Shared types and constants for the smootherstep light fade unit
package slf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int X_BITS    = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS;
    localparam int NUM_CH    = 7;
    localparam int CH_W      = 16;

    localparam logic [X_BITS-1:0]    X_ONE  = X_BITS'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] X_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_START_TIME   = 3'd0,
        REG_DURATION     = 3'd1,
        REG_MODE         = 3'd2,
        REG_START_RGBW   = 3'd3,
        REG_TARGET_RGBW  = 3'd4,
        REG_START_LEVEL  = 3'd5,
        REG_TARGET_LEVEL = 3'd6,
        REG_CT_PAIR      = 3'd7
    } t_reg_idx;

    // control travelling beside the progress value
    typedef struct packed {
        logic valid;
        logic fin;
    } t_ctl;

    typedef struct packed {
        logic [7:0]        on_level;
        logic [7:0]        brightness;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        white;
        logic [15:0]       color_temp;
        logic [X_BITS-1:0] progress;
        logic              finished;
    } t_result;

endpackage

>>> hdl/slf_div.sv
// Elapsed time and pipelined restoring divider giving linear progress
module slf_div
    import slf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [31:0]       i_now_ms,
    input  logic [31:0]       i_start_time,
    input  logic [31:0]       i_duration,
    output t_ctl              o_ctl,
    output logic [X_BITS-1:0] o_x
);

    logic [31:0]          r_rem [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q   [0:DIV_STEPS];
    t_ctl                 r_ctl [0:DIV_STEPS];
    logic [31:0]          n_el;

    // wrapped elapsed time and finished test
    assign n_el = i_now_ms - i_start_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else if (i_en) begin
            r_ctl[0].valid <= i_valid;
        end
        if (i_en) begin
            r_ctl[0].fin <= (i_duration == 32'd0) || (n_el >= i_duration);
            r_rem[0]     <= n_el;
            r_q[0]       <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [32:0] n_sh;
        logic        n_ge;
        logic [32:0] n_sub;

        assign n_sh  = {r_rem[k-1], 1'b0};
        assign n_ge  = n_sh >= {1'b0, i_duration};
        assign n_sub = n_sh - {1'b0, i_duration};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[k].valid <= r_ctl[k-1].valid;
            end
            if (i_en) begin
                r_ctl[k].fin <= r_ctl[k-1].fin;
                r_rem[k]     <= n_ge ? n_sub[31:0] : n_sh[31:0];
                r_q[k]       <= {r_q[k-1][DIV_STEPS-2:0], n_ge};
            end
        end
    end

    assign o_ctl = r_ctl[DIV_STEPS];
    assign o_x   = r_ctl[DIV_STEPS].fin ? X_ONE : {1'b0, r_q[DIV_STEPS]};

endmodule

>>> hdl/slf_ease.sv
// Four-stage smootherstep easing of the progress value
module slf_ease
    import slf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_ctl              i_ctl,
    input  logic [X_BITS-1:0] i_x,
    output t_ctl              o_ctl,
    output logic [X_BITS-1:0] o_x,
    output logic [X_BITS-1:0] o_v
);

    t_ctl              r_ctl [0:3];
    logic [X_BITS-1:0] r_x   [0:3];
    logic [33:0]       r_sq;
    logic [33:0]       r_x2x;
    logic [21:0]       r_p;
    logic [38:0]       r_m;
    logic [X_BITS-1:0] r_v;

    logic [34:0]       n_sq_r;
    logic [X_BITS-1:0] n_x2;
    logic [21:0]       n_pos;
    logic [21:0]       n_neg;
    logic [34:0]       n_x3_r;
    logic [X_BITS-1:0] n_x3;
    logic [39:0]       n_m_r;
    logic [23:0]       n_v;

    // rounding and polynomial terms between the stages
    always_comb begin
        n_sq_r = {1'b0, r_sq} + 35'(X_HALF);
        n_x2   = n_sq_r[FRAC_BITS +: X_BITS];
        n_pos  = 22'(6) * 22'(n_x2) + 22'(10) * 22'(X_ONE);
        n_neg  = 22'(15) * 22'(r_x[0]);
        n_x3_r = {1'b0, r_x2x} + 35'(X_HALF);
        n_x3   = n_x3_r[FRAC_BITS +: X_BITS];
        n_m_r  = {1'b0, r_m} + 40'(X_HALF);
        n_v    = n_m_r[FRAC_BITS +: 24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
            r_ctl[1].valid <= 1'b0;
            r_ctl[2].valid <= 1'b0;
            r_ctl[3].valid <= 1'b0;
        end else if (i_en) begin
            r_ctl[0].valid <= i_ctl.valid;
            r_ctl[1].valid <= r_ctl[0].valid;
            r_ctl[2].valid <= r_ctl[1].valid;
            r_ctl[3].valid <= r_ctl[2].valid;
        end
        if (i_en) begin
            r_ctl[0].fin <= i_ctl.fin;
            r_ctl[1].fin <= r_ctl[0].fin;
            r_ctl[2].fin <= r_ctl[1].fin;
            r_ctl[3].fin <= r_ctl[2].fin;
            r_x[0] <= i_x;
            r_x[1] <= r_x[0];
            r_x[2] <= r_x[1];
            r_x[3] <= r_x[2];
            // x squared
            r_sq   <= 34'(i_x) * 34'(i_x);
            // x cubed product and polynomial
            r_x2x  <= 34'(n_x2) * 34'(r_x[0]);
            r_p    <= (n_pos > n_neg) ? (n_pos - n_neg) : 22'd0;
            // cube times polynomial
            r_m    <= 39'(n_x3) * 39'(r_p);
            // round and clamp to one
            r_v    <= (n_v > 24'(X_ONE)) ? X_ONE : n_v[X_BITS-1:0];
        end
    end

    assign o_ctl = r_ctl[3];
    assign o_x   = r_x[3];
    assign o_v   = r_v;

endmodule

>>> hdl/smootherstep_light_fade_unit.sv
// Throughput: one request per cycle while o_stall is low; the 16-stage divider
// and 4-stage easing pipeline each take a new time sample every enabled cycle,
// a skid stage absorbs stalls.
// Reset (synchronous, active low) clears the configuration registers to 0 and
// empties the pipeline; the configuration port is always ready.
module smootherstep_light_fade_unit
    import slf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [31:0]       i_now_ms,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_on_level,
    output logic [7:0]        o_brightness,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_white,
    output logic [15:0]       o_color_temp,
    output logic [X_BITS-1:0] o_progress,
    output logic              o_finished
);

    `include "smootherstep_light_fade_unit_assert.svh"

    logic [31:0] r_start_time;
    logic [31:0] r_duration;
    logic        r_mode;
    logic [31:0] r_start_rgbw;
    logic [31:0] r_target_rgbw;
    logic [8:0]  r_start_level;
    logic [8:0]  r_target_level;
    logic [31:0] r_ct_pair;

    logic              n_en;
    t_ctl              w_div_ctl;
    logic [X_BITS-1:0] w_div_x;
    t_ctl              w_ease_ctl;
    logic [X_BITS-1:0] w_ease_x;
    logic [X_BITS-1:0] w_ease_v;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time   <= '0;
            r_duration     <= '0;
            r_mode         <= 1'b0;
            r_start_rgbw   <= '0;
            r_target_rgbw  <= '0;
            r_start_level  <= '0;
            r_target_level <= '0;
            r_ct_pair      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_START_TIME:   r_start_time   <= i_cfg_data;
                REG_DURATION:     r_duration     <= i_cfg_data;
                REG_MODE:         r_mode         <= i_cfg_data[0];
                REG_START_RGBW:   r_start_rgbw   <= i_cfg_data;
                REG_TARGET_RGBW:  r_target_rgbw  <= i_cfg_data;
                REG_START_LEVEL:  r_start_level  <= i_cfg_data[8:0];
                REG_TARGET_LEVEL: r_target_level <= i_cfg_data[8:0];
                REG_CT_PAIR:      r_ct_pair      <= i_cfg_data;
                default:          r_mode         <= r_mode;
            endcase
        end
    end

    // pipeline moves whenever the skid stage is empty
    logic r_skid_v;
    assign n_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    slf_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (n_en),
        .i_valid      (i_valid),
        .i_now_ms     (i_now_ms),
        .i_start_time (r_start_time),
        .i_duration   (r_duration),
        .o_ctl        (w_div_ctl),
        .o_x          (w_div_x)
    );

    slf_ease u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (w_div_ctl),
        .i_x     (w_div_x),
        .o_ctl   (w_ease_ctl),
        .o_x     (w_ease_x),
        .o_v     (w_ease_v)
    );

    // start and target values per channel: on, brightness, R, G, B, W, colour temp
    logic [CH_W-1:0]   n_s [0:NUM_CH-1];
    logic [CH_W-1:0]   n_t [0:NUM_CH-1];
    logic              n_fade_up;
    logic [X_BITS-1:0] n_v;

    always_comb begin
        n_fade_up = !r_mode && !r_start_level[8] && r_target_level[8];
        n_t[0] = r_target_level[8] ? CH_W'(8'hFF) : '0;
        n_t[1] = CH_W'(r_target_level[7:0]);
        n_t[2] = CH_W'(r_target_rgbw[31:24]);
        n_t[3] = CH_W'(r_target_rgbw[23:16]);
        n_t[4] = CH_W'(r_target_rgbw[15:8]);
        n_t[5] = CH_W'(r_target_rgbw[7:0]);
        n_t[6] = r_ct_pair[31:16];
        n_s[0] = r_start_level[8] ? CH_W'(8'hFF) : '0;
        n_s[1] = n_fade_up ? '0 : CH_W'(r_start_level[7:0]);
        n_s[2] = n_fade_up ? n_t[2] : CH_W'(r_start_rgbw[31:24]);
        n_s[3] = n_fade_up ? n_t[3] : CH_W'(r_start_rgbw[23:16]);
        n_s[4] = n_fade_up ? n_t[4] : CH_W'(r_start_rgbw[15:8]);
        n_s[5] = n_fade_up ? n_t[5] : CH_W'(r_start_rgbw[7:0]);
        n_s[6] = n_fade_up ? n_t[6] : r_ct_pair[15:0];
        // flash shows the target until finished
        if (r_mode) begin
            n_v = w_ease_ctl.fin ? '0 : X_ONE;
        end else begin
            n_v = w_ease_v;
        end
    end

    // blend products
    t_ctl              r_m_ctl;
    logic [X_BITS-1:0] r_m_x;
    logic [32:0]       r_pa [0:NUM_CH-1];
    logic [32:0]       r_pb [0:NUM_CH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl.valid <= 1'b0;
        end else if (n_en) begin
            r_m_ctl.valid <= w_ease_ctl.valid;
        end
        if (n_en) begin
            r_m_ctl.fin <= w_ease_ctl.fin;
            r_m_x       <= w_ease_x;
            for (int k = 0; k < NUM_CH; k++) begin
                r_pa[k] <= 33'(n_s[k]) * 33'(X_ONE - n_v);
                r_pb[k] <= 33'(n_t[k]) * 33'(n_v);
            end
        end
    end

    // sum and round to nearest
    t_result     n_res;
    logic [33:0] n_sum [0:NUM_CH-1];

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            n_sum[k] = 34'(r_pa[k]) + 34'(r_pb[k]) + 34'(X_HALF);
        end
        n_res.on_level   = n_sum[0][FRAC_BITS +: 8];
        n_res.brightness = n_sum[1][FRAC_BITS +: 8];
        n_res.red        = n_sum[2][FRAC_BITS +: 8];
        n_res.green      = n_sum[3][FRAC_BITS +: 8];
        n_res.blue       = n_sum[4][FRAC_BITS +: 8];
        n_res.white      = n_sum[5][FRAC_BITS +: 8];
        n_res.color_temp = n_sum[6][FRAC_BITS +: 16];
        n_res.progress   = r_m_x;
        n_res.finished   = r_m_ctl.fin;
    end

    // output register with skid stage
    logic    r_out_v;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_m_ctl.valid;
            end
        end else if (r_m_ctl.valid && n_en) begin
            r_skid_v <= 1'b1;
        end
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (n_en) begin
            r_skid <= n_res;
        end
    end

    assign o_valid      = r_out_v;
    assign o_on_level   = r_out.on_level;
    assign o_brightness = r_out.brightness;
    assign o_red        = r_out.red;
    assign o_green      = r_out.green;
    assign o_blue       = r_out.blue;
    assign o_white      = r_out.white;
    assign o_color_temp = r_out.color_temp;
    assign o_progress   = r_out.progress;
    assign o_finished   = r_out.finished;

    // checks
    `SLF_ASSERT_NOW(a_skid_needs_out, r_skid_v, r_out_v)
    `SLF_ASSERT_NOW(a_fin_means_one, r_out_v && r_out.finished, r_out.progress == X_ONE)
    `SLF_ASSERT_NOW(a_one_means_fin, r_out_v && !r_out.finished, r_out.progress < X_ONE)
    `SLF_ASSERT_NEXT(a_skid_holds, r_skid_v && i_stall, r_skid_v)

endmodule
